### hdl/binocular_gaze_to_screen_mapper_top_assert.svh
// Assertion macros for the gaze to screen mapper.
// Included by the top level; depends on nothing else.
`ifndef BINOCULAR_GAZE_TO_SCREEN_MAPPER_TOP_ASSERT_SVH
`define BINOCULAR_GAZE_TO_SCREEN_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BGSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BGSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bgsm_pkg.sv
// Types and constants shared by the gaze to screen mapper modules.
// No dependencies.
package bgsm_pkg;

  localparam int COORD_BITS  = 12;
  localparam int SCREEN_BITS = 13;
  localparam int RECT_BITS   = 4 * COORD_BITS;
  localparam int CFG_DW      = RECT_BITS;
  localparam int CFG_AW      = 3;
  // Magnitude width of a scaling numerator, and so of its quotient.
  localparam int NUM_BITS    = COORD_BITS + SCREEN_BITS + 1;
  localparam int LANES       = 4;
  localparam int OUT_BITS    = 16;

  // Lane order through the divider.
  localparam int LANE_LX = 0;
  localparam int LANE_LY = 1;
  localparam int LANE_RX = 2;
  localparam int LANE_RY = 3;

  localparam logic [CFG_AW-1:0] REG_LEFT_RECT  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RIGHT_RECT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SCREEN_W   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SCREEN_H   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FULL_MODE  = 3'd4;

  localparam logic [1:0] USED_NONE  = 2'd0;
  localparam logic [1:0] USED_LEFT  = 2'd1;
  localparam logic [1:0] USED_RIGHT = 2'd2;
  localparam logic [1:0] USED_BOTH  = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] left_x;
    logic [COORD_BITS-1:0] left_y;
    logic [COORD_BITS-1:0] right_x;
    logic [COORD_BITS-1:0] right_y;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] screen_x;
    logic signed [OUT_BITS-1:0] screen_y;
    logic                       gaze_valid;
    logic [1:0]                 eyes_used;
  } out_item_t;

  // Control traveling alongside the lanes.
  typedef struct packed {
    logic       valid;
    logic [1:0] eye_ok;  // bit 0 left, bit 1 right
  } ctrl_t;

  // One division in flight: divisor, partial remainder, dividend bits, quotient, sign.
  typedef struct packed {
    logic [COORD_BITS-1:0] d;
    logic [COORD_BITS-1:0] r;
    logic [NUM_BITS-1:0]   n;
    logic [NUM_BITS-1:0]   q;
    logic                  neg;
  } lane_t;

endpackage

### hdl/bgsm_front.sv
// Front end: quadrant pick, scaling numerator and divisor for all four lanes.
// Two register stages; depends on bgsm_pkg.
module bgsm_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  bgsm_pkg::in_item_t                      item_i,
  input  logic [bgsm_pkg::RECT_BITS-1:0]          left_rect_i,
  input  logic [bgsm_pkg::RECT_BITS-1:0]          right_rect_i,
  input  logic [bgsm_pkg::SCREEN_BITS-1:0]        screen_w_i,
  input  logic [bgsm_pkg::SCREEN_BITS-1:0]        screen_h_i,
  input  logic                                    full_i,
  output bgsm_pkg::ctrl_t                         ctrl_o,
  output bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0]   lane_o
);
  localparam int CB   = bgsm_pkg::COORD_BITS;
  localparam int SB   = bgsm_pkg::SCREEN_BITS;
  localparam int NW   = bgsm_pkg::NUM_BITS;
  localparam int PAW  = SB - 1 + CB;
  localparam int PBW  = SB + CB + 3;
  localparam int SUMW = PBW + 1;

  logic [CB-1:0]          pos   [bgsm_pkg::LANES];
  logic [CB-1:0]          start [bgsm_pkg::LANES];
  logic [CB-1:0]          size  [bgsm_pkg::LANES];
  logic [SB-2:0]          shalf [bgsm_pkg::LANES];
  logic [bgsm_pkg::LANES-1:0] ok_d, ok_q;
  logic [PAW-1:0]         pa_d [bgsm_pkg::LANES];
  logic [PAW-1:0]         pa_q [bgsm_pkg::LANES];
  logic signed [PBW-1:0]  pb_d [bgsm_pkg::LANES];
  logic signed [PBW-1:0]  pb_q [bgsm_pkg::LANES];
  logic [CB-1:0]          a_d  [bgsm_pkg::LANES];
  logic [CB-1:0]          a_q  [bgsm_pkg::LANES];
  logic                   va_q;
  bgsm_pkg::ctrl_t        ctrl_q;
  bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] lane_q;

  assign pos[bgsm_pkg::LANE_LX]   = item_i.left_x;
  assign pos[bgsm_pkg::LANE_LY]   = item_i.left_y;
  assign pos[bgsm_pkg::LANE_RX]   = item_i.right_x;
  assign pos[bgsm_pkg::LANE_RY]   = item_i.right_y;
  assign start[bgsm_pkg::LANE_LX] = left_rect_i[CB-1:0];
  assign start[bgsm_pkg::LANE_LY] = left_rect_i[2*CB-1:CB];
  assign size[bgsm_pkg::LANE_LX]  = left_rect_i[3*CB-1:2*CB];
  assign size[bgsm_pkg::LANE_LY]  = left_rect_i[4*CB-1:3*CB];
  assign start[bgsm_pkg::LANE_RX] = right_rect_i[CB-1:0];
  assign start[bgsm_pkg::LANE_RY] = right_rect_i[2*CB-1:CB];
  assign size[bgsm_pkg::LANE_RX]  = right_rect_i[3*CB-1:2*CB];
  assign size[bgsm_pkg::LANE_RY]  = right_rect_i[4*CB-1:3*CB];
  assign shalf[bgsm_pkg::LANE_LX] = screen_w_i[SB-1:1];
  assign shalf[bgsm_pkg::LANE_RX] = screen_w_i[SB-1:1];
  assign shalf[bgsm_pkg::LANE_LY] = screen_h_i[SB-1:1];
  assign shalf[bgsm_pkg::LANE_RY] = screen_h_i[SB-1:1];

  for (genvar l = 0; l < bgsm_pkg::LANES; l++) begin : g_lane
    logic [CB:0]          mid, stop, org;
    logic                 lo_half, hi_half;
    logic [CB-1:0]        aw;
    logic signed [CB+1:0] off;
    logic [SB-2:0]        qo;
    logic [SB-1:0]        qw;
    logic signed [SUMW-1:0] sum;

    assign mid     = {1'b0, start[l]} + {2'b0, size[l][CB-1:1]};
    assign stop    = {1'b0, start[l]} + {1'b0, size[l]};
    assign lo_half = (pos[l] >= start[l]) && ({1'b0, pos[l]} <= mid);
    assign hi_half = ({1'b0, pos[l]} > mid) && ({1'b0, pos[l]} <= stop);
    assign aw      = full_i ? size[l] : {1'b0, size[l][CB-1:1]};
    assign org     = (full_i || lo_half) ? {1'b0, start[l]}
                                         : {1'b0, start[l]} + {1'b0, aw};
    assign off     = $signed({2'b0, pos[l]}) - $signed({1'b0, org});
    assign qo      = (full_i || lo_half) ? '0 : shalf[l];
    assign qw      = full_i ? {shalf[l], 1'b0} : {1'b0, shalf[l]};
    assign pa_d[l] = qo * aw;
    assign pb_d[l] = $signed({1'b0, qw}) * off;
    assign a_d[l]  = aw;
    assign ok_d[l] = (full_i || lo_half || hi_half) && (aw != '0);

    // Second stage: add the two products, split into sign and magnitude.
    assign sum = $signed({{(SUMW-PAW){1'b0}}, pa_q[l]}) + SUMW'(pb_q[l]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[l]      <= pa_d[l];
        pb_q[l]      <= pb_d[l];
        a_q[l]       <= a_d[l];
        lane_q[l].d   <= a_q[l];
        lane_q[l].r   <= '0;
        lane_q[l].q   <= '0;
        lane_q[l].neg <= sum[SUMW-1];
        lane_q[l].n   <= sum[SUMW-1] ? NW'(-sum) : NW'(sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      ok_q   <= '0;
      ctrl_q <= '0;
    end else if (en_i) begin
      va_q          <= valid_i;
      ok_q          <= ok_d;
      ctrl_q.valid  <= va_q;
      ctrl_q.eye_ok <= {ok_q[bgsm_pkg::LANE_RX] & ok_q[bgsm_pkg::LANE_RY],
                        ok_q[bgsm_pkg::LANE_LX] & ok_q[bgsm_pkg::LANE_LY]};
    end
  end

  assign ctrl_o = ctrl_q;
  assign lane_o = lane_q;
endmodule

### hdl/bgsm_div_cell.sv
// One cell of the divider chain: one restoring quotient bit for every lane.
// Depends on bgsm_pkg.
module bgsm_div_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  bgsm_pkg::ctrl_t                       ctrl_i,
  input  bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] lane_i,
  output bgsm_pkg::ctrl_t                       ctrl_o,
  output bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] lane_o
);
  localparam int CB = bgsm_pkg::COORD_BITS;
  localparam int NW = bgsm_pkg::NUM_BITS;

  bgsm_pkg::ctrl_t                       ctrl_q;
  bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] lane_d, lane_q;

  for (genvar l = 0; l < bgsm_pkg::LANES; l++) begin : g_lane
    logic [CB:0] trial, diff;
    logic        take;

    assign trial = {lane_i[l].r, lane_i[l].n[NW-1]};
    assign diff  = trial - {1'b0, lane_i[l].d};
    assign take  = trial >= {1'b0, lane_i[l].d};

    always_comb begin
      lane_d[l]     = lane_i[l];
      lane_d[l].r   = take ? diff[CB-1:0] : trial[CB-1:0];
      lane_d[l].n   = {lane_i[l].n[NW-2:0], 1'b0};
      lane_d[l].q   = {lane_i[l].q[NW-2:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign lane_o = lane_q;
endmodule

### hdl/bgsm_div.sv
// Divider chain: NUM_BITS cells, one quotient bit per cell per cycle while en_i is high.
// Depends on bgsm_pkg and bgsm_div_cell.
module bgsm_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  bgsm_pkg::ctrl_t                       ctrl_i,
  input  bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] lane_i,
  output bgsm_pkg::ctrl_t                       ctrl_o,
  output bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] lane_o
);
  localparam int NW = bgsm_pkg::NUM_BITS;

  bgsm_pkg::ctrl_t                       ctrl_c [NW+1];
  bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] lane_c [NW+1];

  assign ctrl_c[0] = ctrl_i;
  assign lane_c[0] = lane_i;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    bgsm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .ctrl_i (ctrl_c[k]),
      .lane_i (lane_c[k]),
      .ctrl_o (ctrl_c[k+1]),
      .lane_o (lane_c[k+1])
    );
  end

  assign ctrl_o = ctrl_c[NW];
  assign lane_o = lane_c[NW];
endmodule

### hdl/binocular_gaze_to_screen_mapper_top.sv
// Binocular gaze to screen mapper, top level.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one pair of iris
// positions per transfer; output channel out_valid_o / out_stall_i /
// out_data_o returns one screen point per input, in order.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Write registers only while the block is idle.
//
// From input transfer to result valid, an item passes two front stages
// (quadrant pick and products, then sum and sign split), a chain of 26
// divider cells that each produce one quotient bit for all four coordinates,
// and the combine and saturate stage in the output register.
// Throughput is one item per cycle. When the output is stalled with a result
// waiting, the whole chain holds and in_stall_o rises in the same cycle.
// Reset clears all valid bits and sets every configuration register to zero.
module binocular_gaze_to_screen_mapper_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bgsm_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bgsm_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bgsm_pkg::CFG_AW-1:0]        cfg_index_i,
  input  logic [bgsm_pkg::CFG_DW-1:0]        cfg_data_i
);
  `include "binocular_gaze_to_screen_mapper_top_assert.svh"

  localparam int SB = bgsm_pkg::SCREEN_BITS;
  localparam int NW = bgsm_pkg::NUM_BITS;
  localparam int OW = bgsm_pkg::OUT_BITS;
  localparam int SW = NW + 2;

  logic [bgsm_pkg::RECT_BITS-1:0] left_rect_q, right_rect_q;
  logic [SB-1:0]                  screen_w_q, screen_h_q;
  logic                           full_q;
  logic                           adv;
  bgsm_pkg::ctrl_t                front_ctrl, div_ctrl;
  bgsm_pkg::lane_t [bgsm_pkg::LANES-1:0] front_lane, div_lane;
  logic signed [NW:0]             val [bgsm_pkg::LANES];
  logic signed [SW-1:0]           sx, sy, gx, gy;
  logic                           out_valid_q;
  bgsm_pkg::out_item_t            out_d, out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_rect_q  <= '0;
      right_rect_q <= '0;
      screen_w_q   <= '0;
      screen_h_q   <= '0;
      full_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bgsm_pkg::REG_LEFT_RECT:  left_rect_q  <= cfg_data_i[bgsm_pkg::RECT_BITS-1:0];
        bgsm_pkg::REG_RIGHT_RECT: right_rect_q <= cfg_data_i[bgsm_pkg::RECT_BITS-1:0];
        bgsm_pkg::REG_SCREEN_W:   screen_w_q   <= cfg_data_i[SB-1:0];
        bgsm_pkg::REG_SCREEN_H:   screen_h_q   <= cfg_data_i[SB-1:0];
        bgsm_pkg::REG_FULL_MODE:  full_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the whole chain unless a result waits on a stalled receiver.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  bgsm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (in_valid_i),
    .item_i       (in_data_i),
    .left_rect_i  (left_rect_q),
    .right_rect_i (right_rect_q),
    .screen_w_i   (screen_w_q),
    .screen_h_i   (screen_h_q),
    .full_i       (full_q),
    .ctrl_o       (front_ctrl),
    .lane_o       (front_lane)
  );

  bgsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctrl_i (front_ctrl),
    .lane_i (front_lane),
    .ctrl_o (div_ctrl),
    .lane_o (div_lane)
  );

  for (genvar l = 0; l < bgsm_pkg::LANES; l++) begin : g_val
    assign val[l] = div_lane[l].neg ? -$signed({1'b0, div_lane[l].q})
                                    :  $signed({1'b0, div_lane[l].q});
  end

  assign sx = SW'(val[bgsm_pkg::LANE_LX]) + SW'(val[bgsm_pkg::LANE_RX]);
  assign sy = SW'(val[bgsm_pkg::LANE_LY]) + SW'(val[bgsm_pkg::LANE_RY]);

  function automatic logic signed [OW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'(2 ** (OW - 1) - 1);
    lo = -SW'(2 ** (OW - 1));
    if (v > hi) begin
      sat = hi[OW-1:0];
    end else if (v < lo) begin
      sat = lo[OW-1:0];
    end else begin
      sat = v[OW-1:0];
    end
  endfunction

  always_comb begin
    out_d = '0;
    gx    = '0;
    gy    = '0;
    case (div_ctrl.eye_ok)
      2'b11: begin
        // Halve toward zero: bias negative sums by one before the shift.
        gx = (sx + $signed(SW'(sx[SW-1]))) >>> 1;
        gy = (sy + $signed(SW'(sy[SW-1]))) >>> 1;
        out_d.eyes_used = bgsm_pkg::USED_BOTH;
      end
      2'b01: begin
        gx = SW'(val[bgsm_pkg::LANE_LX]);
        gy = SW'(val[bgsm_pkg::LANE_LY]);
        out_d.eyes_used = bgsm_pkg::USED_LEFT;
      end
      2'b10: begin
        gx = SW'(val[bgsm_pkg::LANE_RX]);
        gy = SW'(val[bgsm_pkg::LANE_RY]);
        out_d.eyes_used = bgsm_pkg::USED_RIGHT;
      end
      default: out_d.eyes_used = bgsm_pkg::USED_NONE;
    endcase
    out_d.gaze_valid = (div_ctrl.eye_ok != 2'b00);
    out_d.screen_x   = sat(gx);
    out_d.screen_y   = sat(gy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BGSM_ASSERT_NOW(a_used_matches_valid, out_valid_o,
    out_data_o.gaze_valid == (out_data_o.eyes_used != bgsm_pkg::USED_NONE),
    "gaze_valid disagrees with eyes_used")
  `BGSM_ASSERT_NOW(a_invalid_is_zero, out_valid_o && !out_data_o.gaze_valid,
    out_data_o.screen_x == '0 && out_data_o.screen_y == '0,
    "invalid gaze carries a nonzero point")
  `BGSM_ASSERT_NEXT(a_stall_holds_chain, out_valid_o && out_stall_i,
    out_valid_o && $stable(div_ctrl) && $stable(front_ctrl),
    "chain moved while the output was stalled")
endmodule
